>>> src/c_subset_lexer_assert.svh
// Assertion macros for the C subset lexer checker.
// Needs a signal named clk and one named rst in the scope of each use.
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/csl_pkg.sv
// Shared types, codes and character helpers for the C subset lexer.
// No dependencies; every other file of the block but csl_char_if and the assertion header uses it.
`timescale 1ns / 1ps

package csl_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 64;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned KIND_W = 4;
  localparam int unsigned WIN_BYTES = 6;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_BRACE_OPEN  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_BRACE_CLOSE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_PAREN_OPEN  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PAREN_CLOSE = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SEMI        = 4'd4;
  localparam logic [KIND_W-1:0] KIND_INT         = 4'd5;
  localparam logic [KIND_W-1:0] KIND_RETURN      = 4'd6;
  localparam logic [KIND_W-1:0] KIND_IDENT       = 4'd7;
  localparam logic [KIND_W-1:0] KIND_DEC         = 4'd8;
  localparam logic [KIND_W-1:0] KIND_HEX         = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN     = 4'd10;
  localparam logic [KIND_W-1:0] KIND_BAD         = 4'd11;

  // Hex prefix tracking
  localparam logic [1:0] HEX_NONE   = 2'd0;
  localparam logic [1:0] HEX_ZERO   = 2'd1;
  localparam logic [1:0] HEX_PREFIX = 2'd2;
  localparam logic [1:0] HEX_DIGITS = 2'd3;

  // Characters
  localparam logic [7:0] CH_QUOTE       = 8'h22;
  localparam logic [7:0] CH_ZERO        = 8'h30;
  localparam logic [7:0] CH_UNDERSCORE  = 8'h5F;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_X_LOWER     = 8'h78;
  localparam logic [7:0] CH_X_UPPER     = 8'h58;
  localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B;
  localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;
  localparam logic [7:0] CH_PAREN_OPEN  = 8'h28;
  localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;
  localparam logic [7:0] CH_SEMI        = 8'h3B;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_QUOTE,
    MODE_HALT
  } lex_mode_t;

  // Running summary of the word being scanned
  typedef struct packed {
    logic [LEN_W-1:0]               len;
    logic [WIN_BYTES-1:0][7:0]      window;
    logic                           all_dec;
    logic [1:0]                     hex;
  } word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    logic              last;
  } tok_t;

  // Up to two results made by one character
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t r0;
    tok_t r1;
  } res_pair_t;

  function automatic logic dec_char(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic alpha_char(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return dec_char(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic blank_char(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic punct_char(logic [7:0] c);
    return (c == CH_BRACE_OPEN) || (c == CH_BRACE_CLOSE) || (c == CH_PAREN_OPEN) ||
           (c == CH_PAREN_CLOSE) || (c == CH_SEMI);
  endfunction

  function automatic logic [KIND_W-1:0] special_kind(logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_BRACE_OPEN:  k = KIND_BRACE_OPEN;
      CH_BRACE_CLOSE: k = KIND_BRACE_CLOSE;
      CH_PAREN_OPEN:  k = KIND_PAREN_OPEN;
      CH_PAREN_CLOSE: k = KIND_PAREN_CLOSE;
      default:        k = KIND_SEMI;
    endcase
    return k;
  endfunction

  function automatic word_t clear_word();
    word_t w;
    w.len     = '0;
    w.window  = '0;
    w.all_dec = 1'b1;
    w.hex     = HEX_NONE;
    return w;
  endfunction

  // Fold one character into the word summary
  function automatic word_t add_char(word_t w, logic [7:0] c);
    word_t r;
    r = w;
    if (w.len == '0) begin
      r.hex = (c == CH_ZERO) ? HEX_ZERO : HEX_NONE;
    end else if (w.hex == HEX_ZERO) begin
      r.hex = ((c == CH_X_LOWER) || (c == CH_X_UPPER)) ? HEX_PREFIX : HEX_NONE;
    end else if ((w.hex == HEX_PREFIX) || (w.hex == HEX_DIGITS)) begin
      r.hex = is_hex(c) ? HEX_DIGITS : HEX_NONE;
    end
    if (!dec_char(c)) begin
      r.all_dec = 1'b0;
    end
    if (w.len < LEN_W'(WIN_BYTES)) begin
      r.window[w.len[2:0]] = c;
    end
    if (w.len < LEN_MAX) begin
      r.len = w.len + LEN_W'(1);
    end
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] classify(lex_mode_t m, word_t w);
    logic [KIND_W-1:0] k;
    logic kw_int;
    logic kw_ret;
    kw_int = (w.len == LEN_W'(3)) && (w.window[0] == 8'h69) && (w.window[1] == 8'h6E) &&
             (w.window[2] == 8'h74);
    kw_ret = (w.len == LEN_W'(6)) && (w.window[0] == 8'h72) && (w.window[1] == 8'h65) &&
             (w.window[2] == 8'h74) && (w.window[3] == 8'h75) && (w.window[4] == 8'h72) &&
             (w.window[5] == 8'h6E);
    k = KIND_UNKNOWN;
    if (m == MODE_IDENT) begin
      k = kw_int ? KIND_INT : (kw_ret ? KIND_RETURN : KIND_IDENT);
    end else if (m == MODE_NUM) begin
      if (w.all_dec) begin
        k = KIND_DEC;
      end else if (w.hex == HEX_DIGITS) begin
        k = KIND_HEX;
      end
    end
    return k;
  endfunction

endpackage

>>> src/csl_char_if.sv
// Character channel: valid/ready handshake carrying one source byte.
// Uses csl_pkg for nothing; stands alone after the package.
`timescale 1ns / 1ps

interface csl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

>>> src/csl_tok_if.sv
// Token channel: valid/ready handshake carrying one token result.
// Widths from csl_pkg.
`timescale 1ns / 1ps

interface csl_tok_if;
  logic                          valid;
  logic                          ready;
  logic [csl_pkg::KIND_W-1:0]    token_kind;
  logic [csl_pkg::LEN_W-1:0]     token_length;
  logic                          is_last;

  modport source (output valid, output token_kind, output token_length, output is_last,
                  input ready);
  modport sink (input valid, input token_kind, input token_length, input is_last,
                output ready);
endinterface

>>> src/csl_core.sv
// Lexer state and per-character decision logic: mode, word summary, results.
// Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          ch,
  input  logic                end_of_input,
  output csl_pkg::res_pair_t  res
);

  csl_pkg::lex_mode_t mode, mode_next;
  csl_pkg::word_t     word, word_next;

  csl_pkg::word_t          word_add;
  logic [csl_pkg::KIND_W-1:0] close_kind;
  logic                    is_q;
  logic                    takes;
  csl_pkg::res_pair_t      res_raw;

  // Character classes and the closing kind of the pending word
  assign word_add   = csl_pkg::add_char(word, ch);
  assign close_kind = csl_pkg::classify(mode, word);
  assign is_q       = (ch == csl_pkg::CH_QUOTE);
  assign takes      = csl_pkg::dec_char(ch) || csl_pkg::alpha_char(ch) ||
                      ((mode == csl_pkg::MODE_IDENT) && (ch == csl_pkg::CH_UNDERSCORE));

  // Next mode and word
  always_comb begin
    mode_next = mode;
    word_next = word;
    if (mode == csl_pkg::MODE_HALT) begin
      mode_next = mode;
    end else if (end_of_input) begin
      mode_next = csl_pkg::MODE_IDLE;
      word_next = csl_pkg::clear_word();
    end else begin
      case (mode)
        csl_pkg::MODE_QUOTE: begin
          if (is_q) begin
            mode_next = csl_pkg::MODE_IDLE;
            word_next = csl_pkg::clear_word();
          end else begin
            word_next = word_add;
          end
        end
        csl_pkg::MODE_NUM, csl_pkg::MODE_IDENT: begin
          if (takes) begin
            word_next = word_add;
          end else if (is_q) begin
            mode_next = csl_pkg::MODE_QUOTE;
            word_next = csl_pkg::add_char(csl_pkg::clear_word(), ch);
          end else if (csl_pkg::blank_char(ch) || csl_pkg::punct_char(ch)) begin
            mode_next = csl_pkg::MODE_IDLE;
            word_next = csl_pkg::clear_word();
          end else begin
            mode_next = csl_pkg::MODE_HALT;
            word_next = csl_pkg::clear_word();
          end
        end
        default: begin
          word_next = csl_pkg::add_char(csl_pkg::clear_word(), ch);
          if (csl_pkg::blank_char(ch)) begin
            word_next = word;
          end else if (csl_pkg::dec_char(ch)) begin
            mode_next = csl_pkg::MODE_NUM;
          end else if (is_q) begin
            mode_next = csl_pkg::MODE_QUOTE;
          end else if (csl_pkg::alpha_char(ch) || (ch == csl_pkg::CH_UNDERSCORE)) begin
            mode_next = csl_pkg::MODE_IDENT;
          end else if (csl_pkg::punct_char(ch)) begin
            word_next = word;
          end else begin
            mode_next = csl_pkg::MODE_HALT;
            word_next = csl_pkg::clear_word();
          end
        end
      endcase
    end
  end

  // Results made by this character
  always_comb begin
    res_raw = '0;
    if (mode == csl_pkg::MODE_HALT) begin
      res_raw.v0 = 1'b0;
    end else if (end_of_input) begin
      if ((mode != csl_pkg::MODE_IDLE) && (word.len != '0)) begin
        res_raw.v0      = 1'b1;
        res_raw.r0.kind = close_kind;
        res_raw.r0.len  = word.len;
      end
    end else begin
      case (mode)
        csl_pkg::MODE_QUOTE: begin
          if (is_q) begin
            res_raw.v0      = 1'b1;
            res_raw.r0.kind = csl_pkg::KIND_UNKNOWN;
            res_raw.r0.len  = word_add.len;
          end
        end
        csl_pkg::MODE_NUM, csl_pkg::MODE_IDENT: begin
          if (!takes) begin
            res_raw.v0      = 1'b1;
            res_raw.r0.kind = close_kind;
            res_raw.r0.len  = word.len;
            if (!csl_pkg::blank_char(ch) && !is_q) begin
              if (csl_pkg::punct_char(ch)) begin
                res_raw.v1      = 1'b1;
                res_raw.r1.kind = csl_pkg::special_kind(ch);
                res_raw.r1.len  = csl_pkg::LEN_W'(1);
              end else begin
                // Illegal byte drops the pending word
                res_raw.r0.kind = csl_pkg::KIND_BAD;
                res_raw.r0.len  = csl_pkg::LEN_W'(1);
              end
            end
          end
        end
        default: begin
          if (csl_pkg::punct_char(ch)) begin
            res_raw.v0      = 1'b1;
            res_raw.r0.kind = csl_pkg::special_kind(ch);
            res_raw.r0.len  = csl_pkg::LEN_W'(1);
          end else if (!csl_pkg::blank_char(ch) && !csl_pkg::dec_char(ch) && !is_q &&
                       !csl_pkg::alpha_char(ch) && (ch != csl_pkg::CH_UNDERSCORE)) begin
            res_raw.v0      = 1'b1;
            res_raw.r0.kind = csl_pkg::KIND_BAD;
            res_raw.r0.len  = csl_pkg::LEN_W'(1);
          end
        end
      endcase
    end
    res_raw.r0.last = !res_raw.v1;
    res_raw.r1.last = 1'b1;
  end

  // Gate results with the input transaction
  always_comb begin
    res    = res_raw;
    res.v0 = res_raw.v0 & fire;
    res.v1 = res_raw.v1 & fire;
  end

  // Hold state between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= csl_pkg::MODE_IDLE;
      word <= csl_pkg::clear_word();
    end else if (fire) begin
      mode <= mode_next;
      word <= word_next;
    end
  end

endmodule

>>> src/csl_outq.sv
// Result queue: takes up to two tokens a cycle, hands out one a cycle while out_ready.
// Depends on csl_pkg.
`timescale 1ns / 1ps

module csl_outq (
  input  logic                clk,
  input  logic                rst,
  input  csl_pkg::res_pair_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output csl_pkg::tok_t       out_tok
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  csl_pkg::tok_t    entries [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  logic [CNT_W-1:0] push_n;

  // Room for a full pair of results
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_tok   = entries[rptr];
  assign pop       = out_valid && out_ready;
  assign push_n    = CNT_W'(push.v0) + CNT_W'(push.v1);
  assign count_next = count + push_n - CNT_W'(pop);

  // Write entries
  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wptr] <= push.r0;
    end
    if (push.v1) begin
      entries[wptr + PTR_W'(1)] <= push.r1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + push_n[PTR_W-1:0];
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

endmodule

>>> src/c_subset_lexer.sv
// Top level of the C subset lexer: core decision logic plus result queue.
// Depends on csl_pkg, csl_char_if, csl_tok_if, csl_core, csl_outq.
`timescale 1ns / 1ps

// Channel    Dir  Payload                              Transaction
// char_in    in   ch[7:0], end_of_input                one source byte or end mark
// token_out  out  token_kind[3:0], token_length[6:0],  one token result
//                 is_last
//
// One character per cycle when token_out is taken at one per cycle and each
// character gives at most one token; the 4-entry queue has a single read
// port, so the two tokens of a character leave it one at a time.
// A character is taken whenever the queue has room for two tokens.
// Results are registered in the queue when the character is taken.
// Synchronous reset clears mode, word summary and the queue.

module c_subset_lexer (
  input  logic       clk,
  input  logic       rst,
  csl_char_if.sink   char_in,
  csl_tok_if.source  token_out
);

  logic               fire;
  logic               room;
  csl_pkg::res_pair_t res;
  csl_pkg::tok_t      head;

  assign char_in.ready = room;
  assign fire          = char_in.valid && room;

  csl_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .ch           (char_in.ch),
    .end_of_input (char_in.end_of_input),
    .res          (res)
  );

  csl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res),
    .room      (room),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .out_tok   (head)
  );

  // Drive token payload
  assign token_out.token_kind   = head.kind;
  assign token_out.token_length = head.len;
  assign token_out.is_last      = head.last;

endmodule

>>> src/csl_chk.sv
// Port-level checker for the C subset lexer, bound to the top level.
// Depends on csl_pkg and c_subset_lexer_assert.svh.
`timescale 1ns / 1ps
`include "c_subset_lexer_assert.svh"

module csl_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [csl_pkg::KIND_W-1:0]    token_kind,
  input logic [csl_pkg::LEN_W-1:0]     token_length,
  input logic                          is_last
);

  // Stalled token holds
  `CSL_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_length) && $stable(is_last), "stalled token changed")

  // Lengths stay in range
  `CSL_ASSERT_NOW(a_len_range, out_valid, (token_length != '0) && (token_length <= csl_pkg::LEN_MAX), "token length out of range")

  // Single-character kinds have length one
  `CSL_ASSERT_NOW(a_single_len, out_valid && ((token_kind <= csl_pkg::KIND_SEMI) || (token_kind == csl_pkg::KIND_BAD)), token_length == csl_pkg::LEN_W'(1), "one-character token with wrong length")

  // Bad character is the final token until reset
  `CSL_ASSERT_NEXT(a_halt, out_valid && out_ready && (token_kind == csl_pkg::KIND_BAD), !out_valid, "token after bad character")

endmodule

bind c_subset_lexer csl_chk u_csl_chk (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (token_out.valid),
  .out_ready    (token_out.ready),
  .token_kind   (token_out.token_kind),
  .token_length (token_out.token_length),
  .is_last      (token_out.is_last)
);
